// ===== hw/rtl/fcta_pkg.sv =====
// Shared types and constants for the file allocation table access block.
package fcta_pkg;

   localparam int TABLE_BYTES_MAX_DEF = 8192;
   localparam int POS_W = 18;
   localparam int CSR_DATA_W = 14;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_BYTES = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_MODE = 1'd1;
   localparam logic [CSR_DATA_W-1:0] TABLE_BYTES_RST = 14'd8192;

   localparam logic [15:0] ENTRY12_MASK = 16'h0FFF;
   localparam logic [15:0] NIBBLE_LO_MASK = 16'h000F;
   localparam logic [15:0] NIBBLE_HI_MASK = 16'hF000;

   typedef enum logic [1:0] {
      ACT_READ   = 2'd0,
      ACT_WRITE  = 2'd1,
      ACT_FORMAT = 2'd2,
      ACT_NONE   = 2'd3
   } fcta_action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_UPDATE
   } fcta_state_type;

   typedef struct packed {
      logic accept;
      logic sweep;
      logic finish;
   } fcta_cmd_type;

   typedef struct packed {
      logic req_format;
      logic sweep_empty;
      logic sweep_last;
      logic out_free;
   } fcta_stat_type;

endpackage

// ===== hw/rtl/fcta_ctrl.sv =====
// Sequencer for accept, format sweep and result update of the table access block.
module fcta_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output fcta_pkg::fcta_cmd_type cmd,
   input  fcta_pkg::fcta_stat_type stat
);
   import fcta_pkg::*;

   fcta_state_type state_ff;
   fcta_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid) begin
               if (stat.req_format && !stat.sweep_empty) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/fcta_datapath.sv =====
// Byte banks, configuration registers, entry merge logic and result register.
module fcta_datapath #(
   parameter int TABLE_BYTES_MAX = fcta_pkg::TABLE_BYTES_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [fcta_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fcta_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic [1:0]                        req_action,
   input  logic [15:0]                       req_index,
   input  logic [15:0]                       req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [15:0]                       rsp_entry,
   output logic                              rsp_error,
   input  fcta_pkg::fcta_cmd_type            cmd,
   output fcta_pkg::fcta_stat_type           stat
);
   import fcta_pkg::*;

   localparam int ROWS = (TABLE_BYTES_MAX + 1) / 2;
   localparam int ROW_W = $clog2(ROWS);

   logic [CSR_DATA_W-1:0] table_bytes_ff;
   logic                  entry_mode_ff;

   logic [7:0] even_mem_ff [ROWS];
   logic [7:0] odd_mem_ff [ROWS];
   logic [7:0] even_rd_ff;
   logic [7:0] odd_rd_ff;

   fcta_action_type  action_ff;
   logic             odd_index_ff;
   logic [15:0]      value_ff;
   logic             pos_odd_ff;
   logic             ok_ff;
   logic [ROW_W-1:0] even_addr_ff;
   logic [ROW_W-1:0] odd_addr_ff;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [15:0] rsp_entry_ff;
   logic        rsp_error_ff;

   logic [POS_W-1:0] used;
   logic [POS_W-1:0] rows_used;
   logic [POS_W-1:0] req_pos;
   logic [POS_W-1:0] req_even_pos;
   logic             req_ok;
   logic [ROW_W-1:0] req_even_addr;
   logic [ROW_W-1:0] req_odd_addr;

   logic [15:0] media;
   logic        used_ge2;
   logic        used_ge3;
   logic        used_ge4;
   logic [7:0]  fmt_b0;
   logic [7:0]  fmt_b1;
   logic [7:0]  fmt_b2;
   logic [7:0]  fmt_b3;
   logic [7:0]  fmt_even;
   logic [7:0]  fmt_odd;
   logic        sweep_odd_en;

   logic [15:0] pair;
   logic [15:0] rd_entry;
   logic [15:0] wr_entry;
   logic [15:0] new_pair;
   logic [7:0]  upd_even;
   logic [7:0]  upd_odd;
   logic        wr_upd;
   logic        is_access;

   logic             even_we;
   logic             odd_we;
   logic [ROW_W-1:0] even_wa;
   logic [ROW_W-1:0] odd_wa;
   logic [7:0]       even_wd;
   logic [7:0]       odd_wd;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_bytes_ff <= TABLE_BYTES_RST;
         entry_mode_ff  <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TABLE_BYTES: table_bytes_ff <= csr_data;
            CSR_ENTRY_MODE:  entry_mode_ff  <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign used = (POS_W'(table_bytes_ff) > POS_W'(TABLE_BYTES_MAX)) ?
                 POS_W'(TABLE_BYTES_MAX) : POS_W'(table_bytes_ff);
   assign rows_used = (used + POS_W'(1)) >> 1;

   assign req_pos = entry_mode_ff ? {1'b0, req_index, 1'b0} :
                    POS_W'(req_index) + POS_W'(req_index[15:1]);
   assign req_ok = (req_pos + POS_W'(1)) < used;
   assign req_even_pos = (req_pos >> 1) + POS_W'(req_pos[0]);
   assign req_even_addr = req_even_pos[ROW_W-1:0];
   assign req_odd_addr = req_pos[ROW_W:1];

   assign stat.req_format  = (fcta_action_type'(req_action) == ACT_FORMAT);
   assign stat.sweep_empty = (used == '0);
   assign stat.sweep_last  = ((POS_W'(row_ff) + POS_W'(1)) == rows_used);
   assign stat.out_free    = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff    <= fcta_action_type'(req_action);
         odd_index_ff <= req_index[0];
         value_ff     <= req_value;
         pos_odd_ff   <= req_pos[0];
         ok_ff        <= req_ok;
         even_addr_ff <= req_even_addr;
         odd_addr_ff  <= req_odd_addr;
      end
      row_ff <= row_in;
   end

   always_comb begin
      row_in = row_ff;
      if (cmd.accept) begin
         row_in = '0;
      end else if (cmd.sweep) begin
         row_in = row_ff + ROW_W'(1);
      end
   end

   // Format contents: every used byte is cleared except the bytes of entries 0 and 1.
   assign media    = {{8{value_ff[7]}}, value_ff[7:0]};
   assign used_ge2 = used >= POS_W'(2);
   assign used_ge3 = used >= POS_W'(3);
   assign used_ge4 = used >= POS_W'(4);

   always_comb begin
      if (entry_mode_ff) begin
         fmt_b0 = used_ge2 ? media[7:0] : 8'h00;
         fmt_b1 = used_ge2 ? media[15:8] : 8'h00;
         fmt_b2 = used_ge4 ? 8'hFF : 8'h00;
         fmt_b3 = used_ge4 ? 8'hFF : 8'h00;
      end else begin
         fmt_b0 = used_ge2 ? media[7:0] : 8'h00;
         fmt_b1 = {(used_ge3 ? 4'hF : 4'h0), (used_ge2 ? media[11:8] : 4'h0)};
         fmt_b2 = used_ge3 ? 8'hFF : 8'h00;
         fmt_b3 = 8'h00;
      end
   end

   always_comb begin
      case (row_ff)
         ROW_W'(0): begin
            fmt_even = fmt_b0;
            fmt_odd  = fmt_b1;
         end
         ROW_W'(1): begin
            fmt_even = fmt_b2;
            fmt_odd  = fmt_b3;
         end
         default: begin
            fmt_even = 8'h00;
            fmt_odd  = 8'h00;
         end
      endcase
   end

   assign sweep_odd_en = POS_W'({row_ff, 1'b1}) < used;

   assign pair = pos_odd_ff ? {even_rd_ff, odd_rd_ff} : {odd_rd_ff, even_rd_ff};

   always_comb begin
      if (entry_mode_ff) begin
         rd_entry = pair;
         wr_entry = value_ff;
         new_pair = value_ff;
      end else begin
         rd_entry = odd_index_ff ? {4'h0, pair[15:4]} : (pair & ENTRY12_MASK);
         wr_entry = value_ff & ENTRY12_MASK;
         if (odd_index_ff) begin
            new_pair = (pair & NIBBLE_LO_MASK) | {value_ff[11:0], 4'h0};
         end else begin
            new_pair = (pair & NIBBLE_HI_MASK) | wr_entry;
         end
      end
   end

   assign upd_even  = pos_odd_ff ? new_pair[15:8] : new_pair[7:0];
   assign upd_odd   = pos_odd_ff ? new_pair[7:0] : new_pair[15:8];
   assign is_access = (action_ff == ACT_READ) || (action_ff == ACT_WRITE);
   assign wr_upd    = cmd.finish && (action_ff == ACT_WRITE) && ok_ff;

   assign even_we = cmd.sweep || wr_upd;
   assign odd_we  = (cmd.sweep && sweep_odd_en) || wr_upd;
   assign even_wa = cmd.sweep ? row_ff : even_addr_ff;
   assign odd_wa  = cmd.sweep ? row_ff : odd_addr_ff;
   assign even_wd = cmd.sweep ? fmt_even : upd_even;
   assign odd_wd  = cmd.sweep ? fmt_odd : upd_odd;

   always_ff @(posedge clock) begin
      if (even_we) begin
         even_mem_ff[even_wa] <= even_wd;
      end
      if (cmd.accept) begin
         even_rd_ff <= even_mem_ff[req_even_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (odd_we) begin
         odd_mem_ff[odd_wa] <= odd_wd;
      end
      if (cmd.accept) begin
         odd_rd_ff <= odd_mem_ff[req_odd_addr];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_error_ff <= is_access && !ok_ff;
         if (is_access && ok_ff) begin
            rsp_entry_ff <= (action_ff == ACT_WRITE) ? wr_entry : rd_entry;
         end else begin
            rsp_entry_ff <= 16'h0000;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_entry = rsp_entry_ff;
   assign rsp_error = rsp_error_ff;

endmodule

// ===== hw/rtl/fat_cluster_table_access.sv =====
// Top level of the file allocation table access block.
// A read or write beat reads its byte pair from two byte banks (even and odd addresses) in
// the accept cycle; in the update state, once the output register is free, the pair is
// merged, written back and registered as the result. In a format, the clearing sweep writes
// one even/odd byte row per cycle over the table bytes in use and lays down entries 0 and
// 1 on its way. One beat is in work at a time; a finished result waits in the output register
// while the next request beat is accepted.
module fat_cluster_table_access #(
   parameter int TABLE_BYTES_MAX = fcta_pkg::TABLE_BYTES_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [fcta_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fcta_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_action,
   input  logic [15:0]                       req_index,
   input  logic [15:0]                       req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [15:0]                       rsp_entry,
   output logic                              rsp_error
);
   import fcta_pkg::*;

   fcta_cmd_type  cmd;
   fcta_stat_type stat;

   fcta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   fcta_datapath #(
      .TABLE_BYTES_MAX (TABLE_BYTES_MAX)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_action (req_action),
      .req_index  (req_index),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_entry  (rsp_entry),
      .rsp_error  (rsp_error),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
